// ===== hw/rtl/imuf_pkg.sv =====
// Package for the IMU frame receiver: frame constants, phase and kind
// types, and the result record shared by the parser and the result queue.
// Depends on nothing.
package imuf_pkg;

	localparam int PAYLOAD_BYTES = 8;
	localparam int BANK_BYTES    = 8;
	localparam int POS_W         = $clog2(PAYLOAD_BYTES + 1);
	localparam int BIDX_W        = $clog2(BANK_BYTES);
	localparam int BANK_W        = 8 * BANK_BYTES;
	localparam int NUM_KINDS     = 3;

	localparam logic [7:0] TYPE_ANGLE = 8'h53;
	localparam logic [7:0] TYPE_RATE  = 8'h52;
	localparam logic [7:0] TYPE_ACCEL = 8'h51;
	localparam logic [7:0] HDR_SEED   = 8'h55;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ANGLE,
		PH_RATE,
		PH_ACCEL
	} phase_t;

	typedef enum logic [1:0] {
		KIND_ANGLE,
		KIND_RATE,
		KIND_ACCEL
	} kind_t;

	typedef struct packed {
		logic [15:0]        extra_word;
		logic signed [15:0] axis_z;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_x;
		logic               checksum_ok;
		kind_t              frame_kind;
	} result_t;

	function automatic kind_t kind_of(input phase_t ph);
		kind_t k;
		k = KIND_ANGLE;
		case (ph)
			PH_RATE:  k = KIND_RATE;
			PH_ACCEL: k = KIND_ACCEL;
			default:  k = KIND_ANGLE;
		endcase
		return k;
	endfunction

endpackage

// ===== hw/rtl/imuf_parser.sv =====
// Frame parser: input beat register, frame state machine, payload buffer,
// checksum accumulator and the three latched banks.
// Depends on imuf_pkg.
module imuf_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             res_full,
	output logic             res_valid,
	output imuf_pkg::result_t res_data
);
	import imuf_pkg::*;

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                go;

	phase_t              phase_q, phase_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [7:0]          sum_q, sum_d;
	logic                buf_we;
	logic                bank_we;
	logic [7:0]          cbuf_q [BANK_BYTES];
	logic [BANK_W-1:0]   banks_q [NUM_KINDS];
	logic [BANK_W-1:0]   collect;
	logic [BANK_W-1:0]   bank_out;
	kind_t               kind;
	logic                ok;

	assign go       = valid_s1 && !res_full;
	assign in_ready = !valid_s1 || !res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	assign kind = kind_of(phase_q);
	assign ok   = (sum_q == byte_s1);

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		sum_d     = sum_q;
		buf_we    = 1'b0;
		bank_we   = 1'b0;
		res_valid = 1'b0;
		if (go) begin
			unique case (phase_q)
				PH_IDLE: begin
					unique case (byte_s1)
						TYPE_ANGLE: phase_d = PH_ANGLE;
						TYPE_RATE:  phase_d = PH_RATE;
						TYPE_ACCEL: phase_d = PH_ACCEL;
						default:    phase_d = PH_IDLE;
					endcase
					pos_d = '0;
					sum_d = HDR_SEED + byte_s1;
				end
				default: begin
					if (pos_q < POS_W'(PAYLOAD_BYTES)) begin
						buf_we = (pos_q < POS_W'(BANK_BYTES));
						sum_d  = sum_q + byte_s1;
						pos_d  = pos_q + POS_W'(1);
					end else begin
						bank_we   = ok;
						res_valid = 1'b1;
						phase_d   = PH_IDLE;
						pos_d     = '0;
						sum_d     = '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			sum_q   <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			sum_q   <= sum_d;
		end
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			cbuf_q[pos_q[BIDX_W-1:0]] <= byte_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < BANK_BYTES; i++) begin
			collect[8*i +: 8] = cbuf_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KINDS; k++) begin
				banks_q[k] <= '0;
			end
		end else if (bank_we) begin
			banks_q[kind] <= collect;
		end
	end

	assign bank_out = ok ? collect : banks_q[kind];

	always_comb begin
		res_data.frame_kind  = kind;
		res_data.checksum_ok = ok;
		res_data.axis_x      = bank_out[15:0];
		res_data.axis_y      = bank_out[31:16];
		res_data.axis_z      = bank_out[47:32];
		res_data.extra_word  = bank_out[63:48];
	end

endmodule

// ===== hw/rtl/imuf_res_fifo.sv =====
// Two-entry result queue that registers each result and decouples the
// parser from back-pressure on the output stream.
// Depends on imuf_pkg.
module imuf_res_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  imuf_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_ready,
	output imuf_pkg::result_t out_data
);
	import imuf_pkg::*;

	result_t     mem_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  count_q;
	logic        pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== hw/rtl/imu_frame_receiver.sv =====
// IMU frame receiver top level: one received byte per input beat, one result
// beat per completed frame. A checksum beat is held in the input beat register;
// its result is registered in the result queue. Throughput: one byte per cycle,
// set by the single parser stage, stalling only while the result queue is full.
// Asynchronous active-low reset returns the parser to idle and zeroes the banks.
// Depends on imuf_pkg, imuf_parser and imuf_res_fifo.
module imu_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [15:0] axis_x, [31:16] axis_y, [47:32] axis_z,
	                               // [63:48] extra_word
	output logic [2:0]  m_tuser    // [1:0] frame_kind, [2] checksum_ok
);
	import imuf_pkg::*;

	logic    res_valid;
	logic    res_full;
	result_t res_data;
	result_t out_data;

	imuf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.res_full  (res_full),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	imuf_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res_data),
		.full      (res_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data)
	);

	assign m_tdata = {out_data.extra_word, out_data.axis_z, out_data.axis_y, out_data.axis_x};
	assign m_tuser = {out_data.checksum_ok, out_data.frame_kind};

endmodule

// ===== test/imu_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for imu_frame_receiver: a table of directed frames, then random
// frame streams with noise and broken frames, checked against a behavioural frame parser.
// Depends on imuf_pkg and the imu_frame_receiver RTL.
module imu_frame_receiver_tb;
	import imuf_pkg::*;

	localparam int N_DIRECTED   = 32;
	localparam int TARGET_BEATS = 1880;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic [7:0] rx;
		bit         typed;
		result_t    want;
	} row_t;

	localparam result_t NO_RES = '0;
	localparam result_t RATE_EMPTY_BAD = '{extra_word: 16'h0000, axis_z: 16'sh0000,
		axis_y: 16'sh0000, axis_x: 16'sh0000, checksum_ok: 1'b0, frame_kind: KIND_RATE};
	localparam result_t ACCEL_EXTREMES = '{extra_word: 16'hffff, axis_z: 16'sh0000,
		axis_y: 16'sh7fff, axis_x: 16'sh8000, checksum_ok: 1'b1, frame_kind: KIND_ACCEL};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [2:0]  m_tuser;

	// Parser state as the block should hold it.
	phase_t            rx_phase;
	logic [POS_W-1:0]  rx_pos;
	logic [7:0]        rx_sum;
	logic [7:0]        payload [BANK_BYTES];
	logic [BANK_W-1:0] banks [NUM_KINDS];

	result_t frame_q [$];
	int      errors;
	int      live_beats;
	int      frames_seen;
	int      frames_good;
	int      quiet;
	bit      steady;

	row_t directed_rows [N_DIRECTED] = '{
		'{8'h55, 1'b0, NO_RES}, '{8'hff, 1'b0, NO_RES},
		'{8'h52, 1'b0, NO_RES},
		'{8'h53, 1'b0, NO_RES}, '{8'h51, 1'b0, NO_RES}, '{8'h52, 1'b0, NO_RES},
		'{8'h55, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'hff, 1'b0, NO_RES},
		'{8'h01, 1'b0, NO_RES}, '{8'h80, 1'b0, NO_RES},
		'{8'h73, 1'b1, RATE_EMPTY_BAD},
		'{8'h51, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES}, '{8'h80, 1'b0, NO_RES}, '{8'hff, 1'b0, NO_RES},
		'{8'h7f, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
		'{8'hff, 1'b0, NO_RES}, '{8'hff, 1'b0, NO_RES},
		'{8'ha2, 1'b1, ACCEL_EXTREMES},
		'{8'h53, 1'b0, NO_RES},
		'{8'h01, 1'b0, NO_RES}, '{8'h02, 1'b0, NO_RES}, '{8'h03, 1'b0, NO_RES},
		'{8'h04, 1'b0, NO_RES}, '{8'h05, 1'b0, NO_RES}, '{8'h06, 1'b0, NO_RES},
		'{8'h07, 1'b0, NO_RES}, '{8'h08, 1'b0, NO_RES},
		'{8'hcc, 1'b0, NO_RES}
	};

	imu_frame_receiver u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit parse_byte(input logic [7:0] b, output result_t r);
		kind_t             k;
		logic [BANK_W-1:0] bank;
		r = NO_RES;
		if (rx_phase == PH_IDLE) begin
			case (b)
				TYPE_ANGLE: rx_phase = PH_ANGLE;
				TYPE_RATE:  rx_phase = PH_RATE;
				TYPE_ACCEL: rx_phase = PH_ACCEL;
				default:    return 1'b0;
			endcase
			rx_pos = '0;
			rx_sum = HDR_SEED + b;
			return 1'b0;
		end
		if (rx_pos < PAYLOAD_BYTES) begin
			if (rx_pos < BANK_BYTES)
				payload[rx_pos[BIDX_W-1:0]] = b;
			rx_sum = rx_sum + b;
			rx_pos = rx_pos + POS_W'(1);
			return 1'b0;
		end
		// This is the checksum beat, so the frame closes here.
		if (rx_phase == PH_RATE)
			k = KIND_RATE;
		else if (rx_phase == PH_ACCEL)
			k = KIND_ACCEL;
		else
			k = KIND_ANGLE;
		if (rx_sum == b) begin
			for (int i = 0; i < BANK_BYTES; i++)
				bank[8*i +: 8] = payload[i];
			banks[k] = bank;
		end
		r.frame_kind  = k;
		r.checksum_ok = (rx_sum == b);
		r.axis_x      = banks[k][15:0];
		r.axis_y      = banks[k][31:16];
		r.axis_z      = banks[k][47:32];
		r.extra_word  = banks[k][63:48];
		rx_phase = PH_IDLE;
		rx_pos   = '0;
		rx_sum   = '0;
		return 1'b1;
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
		result_t pred;
		bit      busy;
		if (!steady) begin
			while ($urandom_range(99) < 21) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		busy = (rx_phase != PH_IDLE);
		if (parse_byte(b, pred))
			frame_q.push_back(typed ? want : pred);
		if (busy || rx_phase != PH_IDLE)
			live_beats++;
	endtask

	task automatic check_field(input string name, input logic [15:0] want, got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		result_t head;
		if (arst_n && m_tvalid && m_tready) begin
			if (frame_q.size() == 0) begin
				$error("result beat with no frame pending: tuser 0x%0h tdata 0x%0h",
					m_tuser, m_tdata);
				errors++;
			end else begin
				head = frame_q.pop_front();
				check_field("frame_kind", 16'(head.frame_kind), 16'(m_tuser[1:0]));
				check_field("checksum_ok", 16'(head.checksum_ok), 16'(m_tuser[2]));
				check_field("axis_x", head.axis_x, m_tdata[15:0]);
				check_field("axis_y", head.axis_y, m_tdata[31:16]);
				check_field("axis_z", head.axis_z, m_tdata[47:32]);
				check_field("extra_word", head.extra_word, m_tdata[63:48]);
				frames_seen++;
				if (head.checksum_ok)
					frames_good++;
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 21);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("Timed out with %0d results outstanding.", frame_q.size());
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		logic [7:0] ftype;
		logic [7:0] pb;
		logic [7:0] csum;
		int         plen;
		int         roll;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		steady   = 1'b0;
		errors   = 0;
		quiet    = 0;
		rx_phase = PH_IDLE;
		rx_pos   = '0;
		rx_sum   = '0;
		for (int i = 0; i < BANK_BYTES; i++)
			payload[i] = '0;
		for (int k = 0; k < NUM_KINDS; k++)
			banks[k] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);

		for (int f = 0; live_beats < TARGET_BEATS; f++) begin
			steady = (f >= 40 && f < 100);
			if (f % 150 == 149) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				wait (frame_q.size() == 0);
			end
			// Close any frame left open by a truncated one before starting afresh.
			while (rx_phase != PH_IDLE)
				send_byte(8'($urandom_range(255)), 1'b0, NO_RES);
			roll = $urandom_range(99);
			if (roll < 8) begin
				repeat ($urandom_range(1, 3))
					send_byte(8'($urandom_range(255)), 1'b0, NO_RES);
			end else begin
				case ($urandom_range(2))
					0:       ftype = TYPE_ANGLE;
					1:       ftype = TYPE_RATE;
					default: ftype = TYPE_ACCEL;
				endcase
				plen = ($urandom_range(99) < 6) ? $urandom_range(0, PAYLOAD_BYTES - 1)
					: PAYLOAD_BYTES;
				csum = HDR_SEED + ftype;
				send_byte(ftype, 1'b0, NO_RES);
				for (int i = 0; i < plen; i++) begin
					if ($urandom_range(7) == 0) begin
						case ($urandom_range(3))
							0:       pb = 8'h00;
							1:       pb = 8'hff;
							2:       pb = 8'h80;
							default: pb = 8'h7f;
						endcase
					end else begin
						pb = 8'($urandom_range(255));
					end
					csum = csum + pb;
					send_byte(pb, 1'b0, NO_RES);
				end
				if (plen == PAYLOAD_BYTES) begin
					if ($urandom_range(99) < 75)
						send_byte(csum, 1'b0, NO_RES);
					else
						send_byte(8'($urandom_range(255)), 1'b0, NO_RES);
				end
			end
		end

		s_tvalid <= 1'b0;
		steady = 1'b0;
		wait (frame_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d frame beats plus idle noise; %0d frames closed, %0d of them good.",
			live_beats, frames_seen, frames_good);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
